FILE: hw/rtl/rsdp_pkg.sv
`timescale 1ns / 1ps

package rsdp_pkg;

	// candidate tracking
	localparam int NUM_SLOTS = 3;
	localparam int AGE_W     = 6;

	// candidate byte offsets
	localparam logic [AGE_W-1:0] SIG_LEN   = AGE_W'(8);
	localparam logic [AGE_W-1:0] REV_AT    = AGE_W'(15);
	localparam logic [AGE_W-1:0] SHORT_END = AGE_W'(19);
	localparam logic [AGE_W-1:0] LONG_END  = AGE_W'(35);

	// revision from which the extended checksum applies
	localparam logic [7:0] EXT_REV = 8'd2;

	// "RSD PTR "
	localparam logic [7:0] SIG_BYTES [8] = '{
		8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
	};

	typedef struct packed {
		logic step;
		logic alloc;
		logic clear;
	} slot_ctl_t;

	typedef struct packed {
		logic       active;
		logic       hit;
		logic [7:0] revision;
	} slot_stat_t;

endpackage

FILE: hw/rtl/rsdp_slot.sv
`timescale 1ns / 1ps

module rsdp_slot #(
	parameter int ADDR_BITS = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rsdp_pkg::slot_ctl_t    ctl,
	input  logic [7:0]             data_byte,
	input  logic [ADDR_BITS-1:0]   pos,
	output rsdp_pkg::slot_stat_t   stat,
	output logic [ADDR_BITS-1:0]   start
);

	logic                       active_q;
	logic [rsdp_pkg::AGE_W-1:0] age_q;
	logic                       sig_ok_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 rev_q;
	logic [ADDR_BITS-1:0]       start_q;

	logic [rsdp_pkg::AGE_W-1:0] cur_age;
	logic                       cur_sig;
	logic [7:0]                 cur_sum;
	logic [7:0]                 cur_rev;
	logic [ADDR_BITS-1:0]       cur_start;
	logic                       live;
	logic                       sig_ok_n;
	logic [7:0]                 sum_n;
	logic [7:0]                 rev_n;
	logic                       hit;
	logic                       keep;

	always_comb begin
		// a freshly allocated candidate starts from clean values
		cur_age   = ctl.alloc ? '0 : age_q;
		cur_sig   = ctl.alloc ? 1'b1 : sig_ok_q;
		cur_sum   = ctl.alloc ? 8'd0 : sum_q;
		cur_rev   = ctl.alloc ? 8'd0 : rev_q;
		cur_start = ctl.alloc ? pos : start_q;
		live      = ctl.alloc | active_q;

		sig_ok_n = cur_sig;
		if (cur_age < rsdp_pkg::SIG_LEN && data_byte != rsdp_pkg::SIG_BYTES[cur_age[2:0]]) begin
			sig_ok_n = 1'b0;
		end
		sum_n = cur_sum + data_byte;
		rev_n = (cur_age == rsdp_pkg::REV_AT) ? data_byte : cur_rev;

		hit  = 1'b0;
		keep = live;
		if (cur_age == rsdp_pkg::SHORT_END) begin
			hit  = live && sig_ok_n && sum_n == 8'd0 && rev_n < rsdp_pkg::EXT_REV;
			keep = live && sig_ok_n && sum_n == 8'd0 && rev_n >= rsdp_pkg::EXT_REV;
		end else if (cur_age >= rsdp_pkg::LONG_END) begin
			hit  = live && cur_age == rsdp_pkg::LONG_END && sum_n == 8'd0;
			keep = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.clear) begin
			active_q <= 1'b0;
		end else if (ctl.step) begin
			active_q <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			age_q    <= cur_age + rsdp_pkg::AGE_W'(1);
			sig_ok_q <= sig_ok_n;
			sum_q    <= sum_n;
			rev_q    <= rev_n;
			start_q  <= cur_start;
		end
	end

	assign stat.active   = active_q;
	assign stat.hit      = ctl.step & hit;
	assign stat.revision = rev_n;
	assign start         = cur_start;

endmodule

FILE: hw/rtl/rsdp_signature_checksum_scanner_unit.sv
`timescale 1ns / 1ps

// Scans a memory window one byte per item for the root system description
// pointer. Every SCAN_STEP-aligned offset opens a candidate; a candidate
// passes when its first 8 bytes read "RSD PTR " and its first 20 bytes sum
// to zero mod 256, and, where its revision byte (offset 15) is 2 or more,
// its first 36 bytes also sum to zero. Three candidate trackers run side by
// side. The earliest passing candidate gives one result with found = 1, its
// offset and revision; a window that ends without one gives found = 0 on its
// last byte. A candidate cut off by the window end is invalid. Bytes after a
// find are consumed without effect, and the last byte of a window returns
// everything to the start state, so the next item opens a new window at
// offset 0. One item is taken per clock while the output is not stalled:
// each item passes an input register, the checksum and signature update in
// the trackers, and a result register. The input register lets an item be
// taken while a result waits at the output.

module rsdp_signature_checksum_scanner_unit #(
	parameter int SCAN_STEP        = 16,
	parameter int WINDOW_ADDR_BITS = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [WINDOW_ADDR_BITS-1:0] match_offset,
	output logic [7:0]                  revision
);

	localparam int PH_W = $clog2(SCAN_STEP);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// window position and phase within the scan step
	logic [WINDOW_ADDR_BITS-1:0] pos_q;
	logic [PH_W-1:0]             phase_q;
	logic                        already_found_q;

	// result register
	logic                        out_valid_q;
	logic                        found_q;
	logic [WINDOW_ADDR_BITS-1:0] offset_q;
	logic [7:0]                  rev_q;

	logic                        advance;
	logic                        step;
	logic                        produce;
	logic [WINDOW_ADDR_BITS-1:0] pos_inc;

	rsdp_pkg::slot_ctl_t         slot_ctl   [rsdp_pkg::NUM_SLOTS];
	rsdp_pkg::slot_stat_t        slot_stat  [rsdp_pkg::NUM_SLOTS];
	logic [WINDOW_ADDR_BITS-1:0] slot_start [rsdp_pkg::NUM_SLOTS];

	logic                        best_hit;
	logic [WINDOW_ADDR_BITS-1:0] best_start;
	logic [7:0]                  best_rev;
	logic                        taken;

	// the item in the input stage moves on when the result register is free
	// or being emptied in this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	// once a pointer is found the rest of the window is passed over
	assign step     = advance && !already_found_q;
	assign pos_inc  = pos_q + WINDOW_ADDR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// candidate allocation: first free tracker on an aligned offset
	always_comb begin
		taken = 1'b0;
		for (int i = 0; i < rsdp_pkg::NUM_SLOTS; i++) begin
			slot_ctl[i].step  = step;
			slot_ctl[i].clear = advance && last_s1;
			slot_ctl[i].alloc = 1'b0;
			if (step && phase_q == '0 && !taken && !slot_stat[i].active) begin
				slot_ctl[i].alloc = 1'b1;
				taken             = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < rsdp_pkg::NUM_SLOTS; g++) begin : g_slot
		rsdp_slot #(
			.ADDR_BITS(WINDOW_ADDR_BITS)
		) u_slot (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (slot_ctl[g]),
			.data_byte(byte_s1),
			.pos      (pos_q),
			.stat     (slot_stat[g]),
			.start    (slot_start[g])
		);
	end

	// lowest offset wins when several candidates pass on the same byte
	always_comb begin
		best_hit   = 1'b0;
		best_start = '0;
		best_rev   = 8'd0;
		for (int i = 0; i < rsdp_pkg::NUM_SLOTS; i++) begin
			if (slot_stat[i].hit && (!best_hit || slot_start[i] < best_start)) begin
				best_hit   = 1'b1;
				best_start = slot_start[i];
				best_rev   = slot_stat[i].revision;
			end
		end
	end

	assign produce = best_hit || (advance && last_s1 && !already_found_q);

	// position and phase; phase tracks position modulo the scan step,
	// including across a wrap of the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			phase_q         <= '0;
			already_found_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q           <= '0;
				phase_q         <= '0;
				already_found_q <= 1'b0;
			end else begin
				pos_q <= pos_inc;
				if (pos_inc == '0 || phase_q == PH_W'(SCAN_STEP - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + PH_W'(1);
				end
				if (best_hit) begin
					already_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a not-found item carries zero offset and revision
	always_ff @(posedge clk) begin
		if (produce) begin
			found_q  <= best_hit;
			offset_q <= best_start;
			rev_q    <= best_rev;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;
	assign revision     = rev_q;

endmodule

FILE: hw/rtl/rsdp_checker.sv
`timescale 1ns / 1ps

module rsdp_checker #(
	parameter int WINDOW_ADDR_BITS = 17
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [7:0]                  data_byte,
	input logic                        last_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        found,
	input logic [WINDOW_ADDR_BITS-1:0] match_offset,
	input logic [7:0]                  revision
);

	// an offered item holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("offered item changed before it was taken");

	// a not-found item carries no offset and no revision
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0 && revision == 8'd0)
		else $error("not-found item with non-zero fields");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
			&& $stable(match_offset) && $stable(revision))
		else $error("stalled result changed");

	// a result appearing on an empty output comes from an item taken earlier, through the input and result registers
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input item");

endmodule

bind rsdp_signature_checksum_scanner_unit rsdp_checker #(
	.WINDOW_ADDR_BITS(WINDOW_ADDR_BITS)
) u_rsdp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.data_byte   (data_byte),
	.last_byte   (last_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.match_offset(match_offset),
	.revision    (revision)
);

FILE: verif/tb_rsdp_signature_checksum_scanner_unit.sv
`timescale 1ns / 1ps

module tb_rsdp_signature_checksum_scanner_unit;

	// block configuration as built here
	localparam int STRIDE       = 16;
	localparam int ADDR_W       = 17;
	localparam int TRACKERS     = 3;
	localparam int SHORT_SPAN   = 20;
	localparam int LONG_SPAN    = 36;
	localparam int REV_BYTE     = 15;
	localparam int SIG_SPAN     = 8;
	localparam logic [7:0] EXT_REV_MIN = 8'd2;

	// "RSD PTR " as it appears in memory
	localparam logic [7:0] SIGNATURE [SIG_SPAN] = '{
		8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
	};

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_ITEMS  = 640;

	// idle phases: sender mostly busy, then receiver mostly busy, then flat out
	localparam logic [1:0] PH_SLOW_SINK = 2'd0;
	localparam logic [1:0] PH_SLOW_SRC  = 2'd1;
	localparam logic [1:0] PH_FULL_RATE = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
		logic [1:0] phase;
	} window_byte_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] offset;
		logic [7:0]        rev;
	} scan_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_ready;
	logic              found;
	logic [ADDR_W-1:0] match_offset;
	logic [7:0]        revision;

	rsdp_signature_checksum_scanner_unit #(
		.SCAN_STEP       (STRIDE),
		.WINDOW_ADDR_BITS(ADDR_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_offset(match_offset),
		.revision    (revision)
	);

	// bytes waiting to be offered, and results the scan should still produce
	window_byte_t pending_bytes [$];
	scan_result_t expected_finds [$];

	// predictor state: one running candidate per tracker
	logic [ADDR_W-1:0] scan_pos;
	logic              trk_live   [TRACKERS];
	logic [ADDR_W-1:0] trk_base   [TRACKERS];
	logic              trk_sig_ok [TRACKERS];
	logic [7:0]        trk_sum    [TRACKERS];
	logic [7:0]        trk_rev    [TRACKERS];
	logic              hit_seen;

	// bookkeeping
	window_byte_t next_byte;
	logic [1:0]   cur_phase;
	logic         byte_taken;
	int           items_queued;
	int           windows_queued;
	int           bytes_accepted;
	int           finds_seen;
	int           misses_seen;
	int           failures;
	int           cycle_count;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int sender_idle_pct(input logic [1:0] ph);
		case (ph)
			PH_SLOW_SINK: return 21;
			PH_SLOW_SRC:  return 88;
			default:      return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct(input logic [1:0] ph);
		case (ph)
			PH_SLOW_SINK: return 88;
			PH_SLOW_SRC:  return 21;
			default:      return 0;
		endcase
	endfunction

	// back to the start-of-window state
	task automatic clear_scan();
		scan_pos = '0;
		for (int i = 0; i < TRACKERS; i++) begin
			trk_live[i]   = 1'b0;
			trk_base[i]   = '0;
			trk_sig_ok[i] = 1'b0;
			trk_sum[i]    = 8'd0;
			trk_rev[i]    = 8'd0;
		end
		hit_seen = 1'b0;
	endtask

	// advance the scan by one byte and record the result it causes, if any
	task automatic scan_byte(input logic [7:0] b, input logic is_last);
		logic [ADDR_W-1:0] k;
		logic              placed;
		logic              passed;
		logic              emitted;
		int                winner;
		winner  = -1;
		emitted = 1'b0;
		if (!hit_seen) begin
			// aligned offset opens a candidate in the first free tracker
			placed = 1'b0;
			if (scan_pos % STRIDE == 0) begin
				for (int i = 0; i < TRACKERS; i++) begin
					if (!placed && !trk_live[i]) begin
						placed        = 1'b1;
						trk_live[i]   = 1'b1;
						trk_base[i]   = scan_pos;
						trk_sig_ok[i] = 1'b1;
						trk_sum[i]    = 8'd0;
						trk_rev[i]    = 8'd0;
					end
				end
			end
			for (int i = 0; i < TRACKERS; i++) begin
				if (trk_live[i]) begin
					k      = scan_pos - trk_base[i];
					passed = 1'b0;
					if (k < SIG_SPAN && b != SIGNATURE[k[2:0]])
						trk_sig_ok[i] = 1'b0;
					trk_sum[i] = trk_sum[i] + b;
					if (k == REV_BYTE)
						trk_rev[i] = b;
					if (k == SHORT_SPAN - 1) begin
						if (!trk_sig_ok[i] || trk_sum[i] != 8'd0)
							trk_live[i] = 1'b0;
						else if (trk_rev[i] < EXT_REV_MIN)
							passed = 1'b1;
					end else if (k == LONG_SPAN - 1) begin
						passed      = (trk_sum[i] == 8'd0);
						trk_live[i] = 1'b0;
					end else if (k >= LONG_SPAN) begin
						trk_live[i] = 1'b0;
					end
					if (passed) begin
						trk_live[i] = 1'b0;
						// lower offset wins a tie on the same byte
						if (winner < 0 || trk_base[i] < trk_base[winner])
							winner = i;
					end
				end
			end
			if (winner >= 0) begin
				expected_finds.push_back(
					scan_result_t'{1'b1, trk_base[winner], trk_rev[winner]});
				hit_seen = 1'b1;
				emitted  = 1'b1;
			end
		end
		if (is_last) begin
			if (!emitted && !hit_seen)
				expected_finds.push_back(scan_result_t'{1'b0, '0, 8'd0});
			clear_scan();
		end else begin
			scan_pos = scan_pos + 1'b1;
		end
	endtask

	// window of random bytes
	function automatic void fresh(ref logic [7:0] win [$], input int len);
		win.delete();
		for (int i = 0; i < len; i++)
			win.push_back(8'($urandom));
	endfunction

	// drop a well-formed root pointer into the window, clipped at its end
	function automatic void plant(ref logic [7:0] win [$], input int at,
			input logic [7:0] rev);
		logic [7:0] rec [LONG_SPAN];
		logic [7:0] acc;
		for (int i = 0; i < LONG_SPAN; i++)
			rec[i] = 8'($urandom);
		for (int i = 0; i < SIG_SPAN; i++)
			rec[i] = SIGNATURE[i];
		rec[REV_BYTE] = rev;
		// byte 8 balances the short checksum, byte 32 the extended one
		rec[8] = 8'd0;
		acc    = 8'd0;
		for (int i = 0; i < SHORT_SPAN; i++)
			acc = acc + rec[i];
		rec[8]  = -acc;
		rec[32] = 8'd0;
		acc     = 8'd0;
		for (int i = 0; i < LONG_SPAN; i++)
			acc = acc + rec[i];
		rec[32] = -acc;
		for (int i = 0; i < LONG_SPAN; i++)
			if (at + i < win.size())
				win[at + i] = rec[i];
	endfunction

	function automatic void queue_window(ref logic [7:0] win [$], input logic [1:0] ph);
		for (int i = 0; i < win.size(); i++)
			pending_bytes.push_back(window_byte_t'{win[i], i == win.size() - 1, ph});
		items_queued   += win.size();
		windows_queued += 1;
	endfunction

	function automatic logic [7:0] pick_revision();
		case ($urandom_range(4))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return EXT_REV_MIN;
			3:       return 8'($urandom_range(3, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	// directed windows: field extremes and the corner cases of the scan
	task automatic build_directed();
		logic [7:0] win [$];
		// single-byte windows with no candidate able to finish
		fresh(win, 1); win[0] = 8'h00; queue_window(win, PH_SLOW_SINK);
		fresh(win, 1); win[0] = 8'hFF; queue_window(win, PH_SLOW_SINK);
		// short pointer completing on the last byte
		fresh(win, 20); plant(win, 0, 8'd0); queue_window(win, PH_SLOW_SINK);
		// extended pointer completing on the last byte
		fresh(win, 36); plant(win, 0, EXT_REV_MIN); queue_window(win, PH_SLOW_SINK);
		// extended pointer cut off one byte short
		fresh(win, 35); plant(win, 0, EXT_REV_MIN); queue_window(win, PH_SLOW_SINK);
		// find mid-window, trailing bytes and the last byte give nothing more
		fresh(win, 48); plant(win, 16, 8'd1); queue_window(win, PH_SLOW_SINK);
		// extended at 0, overwritten from byte 16 by a short one at 16 that ends on byte 35
		fresh(win, 36); plant(win, 0, EXT_REV_MIN); plant(win, 16, 8'd0);
		queue_window(win, PH_SLOW_SINK);
		// top revision value
		fresh(win, 80); plant(win, 32, 8'hFF); queue_window(win, PH_SLOW_SINK);
		// extended checksum broken
		fresh(win, 36); plant(win, 0, EXT_REV_MIN); win[30] ^= 8'h01;
		queue_window(win, PH_SLOW_SINK);
		// signature broken in its last byte
		fresh(win, 20); plant(win, 0, 8'd0); win[7] ^= 8'h80;
		queue_window(win, PH_SLOW_SINK);
		// short checksum broken, later candidate good
		fresh(win, 52); plant(win, 0, 8'd0); win[12] ^= 8'h10; plant(win, 32, 8'd1);
		queue_window(win, PH_SLOW_SINK);
	endtask

	// random window holding a few planted pointers, some of them damaged
	task automatic build_random_window(input logic [1:0] ph);
		logic [7:0] win [$];
		int         len;
		int         n_rec;
		int         at;
		int         idx;
		case ($urandom_range(9))
			0:       len = $urandom_range(1, 19);
			1:       len = $urandom_range(100, 200);
			default: len = $urandom_range(20, 80);
		endcase
		fresh(win, len);
		n_rec = $urandom_range(0, 3);
		repeat (n_rec) begin
			at = STRIDE * $urandom_range(0, (len - 1) / STRIDE);
			plant(win, at, pick_revision());
			if ($urandom_range(99) < 30) begin
				idx = at + $urandom_range(0, LONG_SPAN - 1);
				if (idx < len)
					win[idx] ^= 8'(1 << $urandom_range(7));
			end
		end
		queue_window(win, ph);
	endtask

	// driver: a new item only once the previous one has gone, at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (pending_bytes.size() != 0 &&
				    $urandom_range(99) >= sender_idle_pct(pending_bytes[0].phase)) begin
					next_byte  = pending_bytes.pop_front();
					cur_phase  = next_byte.phase;
					in_valid  <= 1'b1;
					data_byte <= next_byte.data;
					last_byte <= next_byte.is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			byte_taken = 1'b0;
			out_ready <= ($urandom_range(99) >= receiver_idle_pct(cur_phase));
		end
	end

	// monitor: accepted bytes feed the predictor, accepted results are checked
	always @(posedge clk) begin
		scan_result_t exp_res;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				byte_taken = 1'b1;
				bytes_accepted++;
				scan_byte(data_byte, last_byte);
			end
			if (out_valid && out_ready) begin
				if (found === 1'b1)
					finds_seen++;
				else
					misses_seen++;
				if (expected_finds.size() == 0) begin
					$error("result with none pending: found %0d offset %0d revision %0d",
						found, match_offset, revision);
					failures++;
				end else begin
					exp_res = expected_finds.pop_front();
					if (found !== exp_res.found) begin
						$error("found: expected %0d, got %0d", exp_res.found, found);
						failures++;
					end
					if (match_offset !== exp_res.offset) begin
						$error("match_offset: expected %0d, got %0d",
							exp_res.offset, match_offset);
						failures++;
					end
					if (revision !== exp_res.rev) begin
						$error("revision: expected %0d, got %0d", exp_res.rev, revision);
						failures++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("[rsdp_signature_checksum_scanner_unit] ERROR");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'd0;
		last_byte      = 1'b0;
		out_ready      = 1'b0;
		byte_taken     = 1'b0;
		cur_phase      = PH_SLOW_SINK;
		items_queued   = 0;
		windows_queued = 0;
		bytes_accepted = 0;
		finds_seen     = 0;
		misses_seen    = 0;
		failures       = 0;
		clear_scan();

		// stimulus is laid out up front, phase by phase
		build_directed();
		while (items_queued < PHASE_ITEMS)
			build_random_window(PH_SLOW_SINK);
		while (items_queued < 2 * PHASE_ITEMS)
			build_random_window(PH_SLOW_SRC);
		while (items_queued < 3 * PHASE_ITEMS)
			build_random_window(PH_FULL_RATE);

		// release reset away from the rising edge, once only
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every item offered and taken, then every result back, then a short drain
		@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_finds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("scanned %0d windows, %0d bytes, slow receiver, slow sender, then full rate",
			windows_queued, bytes_accepted);
		$display("results: %0d pointers found, %0d windows without one, %0d mismatches",
			finds_seen, misses_seen, failures);
		if (failures == 0)
			$display("[rsdp_signature_checksum_scanner_unit] OK");
		else
			$display("[rsdp_signature_checksum_scanner_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rsdp_pkg.sv
hw/rtl/rsdp_slot.sv
hw/rtl/rsdp_signature_checksum_scanner_unit.sv
hw/rtl/rsdp_checker.sv
verif/tb_rsdp_signature_checksum_scanner_unit.sv
